// ----- rtl/core/hrs_pkg.sv -----
// Shared types and constants for the cubic Hermite resampler.
package hrs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 25;
    localparam int TOTAL_W    = 16;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_OUTS   = 64;
    localparam int RUN_CNT_W  = $clog2(MAX_OUTS);
    localparam int PRIME_W    = 2;

    // Horner accumulator: every partial sum stays below 2^21 in magnitude.
    localparam int ACC_W = 22;
    localparam int MAG_W = ACC_W - 1;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TOTAL = 1'b1;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 25'd16777216;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd4096;
    localparam logic [PRIME_W-1:0] PRIME_FULL  = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       begin_req;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       run_last;
        logic                       total_done;
    } out_beat_t;

    typedef enum logic [1:0] {
        ADD_NEG_B,
        ADD_C,
        ADD_X0
    } add_sel_t;

    typedef struct packed {
        logic     load;
        logic     coef;
        logic     load_a;
        logic     mul;
        logic     add;
        add_sel_t sel;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic run_ok;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/hrs_datapath.sv -----
// Datapath: window, phase, counters, Hermite coefficient and Horner evaluation.
module hrs_datapath
    import hrs_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_beat_t              s_data,
    output out_beat_t             m_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);

    localparam int F     = PHASE_FRAC_BITS;
    localparam int CW    = (F + 1 > STEP_W) ? F + 1 : STEP_W;
    localparam int PROD_W = MAG_W + F;
    localparam int RND_W  = PROD_W + 1;
    localparam logic [CW-1:0] ONE_C = CW'(1) << F;
    localparam logic [CW-1:0] MIN_C = CW'(1) << (F - 6);

    logic [STEP_W-1:0]          step_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic signed [SAMPLE_W-1:0] win_reg [4];
    logic signed [SAMPLE_W-1:0] win_next [4];
    logic [F-1:0]               phase_reg;
    logic [PRIME_W-1:0]         prime_reg;
    logic [TOTAL_W-1:0]         made_reg;
    logic [RUN_CNT_W-1:0]       n_reg;
    logic                       run_ok_reg;

    logic signed [19:0]         a2_reg;
    logic signed [20:0]         nb2_reg;
    logic signed [16:0]         c2_reg;
    logic signed [16:0]         x02_reg;

    logic signed [ACC_W-1:0]    acc_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       sign_reg;

    out_beat_t                  out_reg;
    logic                       m_valid_reg;

    // load decode
    logic [PRIME_W-1:0]         prime_eff;
    logic [TOTAL_W-1:0]         made_eff;

    // coefficients
    logic signed [ACC_W-1:0]    xm1_e, x0_e, x1_e, x2_e;
    logic signed [ACC_W-1:0]    c2_w, v2_w, w2_w, a2_w, b2_w;

    // multiply / round
    logic signed [ACC_W-1:0]    acc_neg;
    logic [MAG_W-1:0]           acc_mag;
    logic [RND_W-1:0]           rnd;
    logic [MAG_W-1:0]           q_mag;
    logic signed [ACC_W-1:0]    q_signed;
    logic signed [ACC_W-1:0]    addend;

    // output
    logic [MAG_W:0]             mag_inc;
    logic signed [ACC_W-1:0]    half_w;
    logic signed [SAMPLE_W-1:0] sat_w;
    logic [CW-1:0]              step_ext;
    logic [CW-1:0]              step_cl;
    logic [F:0]                 step_c;
    logic [F:0]                 phase_sum;
    logic [TOTAL_W:0]           made_inc;
    logic                       last_w;
    logic                       done_w;

    always_comb begin
        prime_eff = s_data.begin_req ? '0 : prime_reg;
        made_eff  = s_data.begin_req ? '0 : made_reg;
        win_next[0] = s_data.begin_req ? '0 : win_reg[1];
        win_next[1] = s_data.begin_req ? '0 : win_reg[2];
        win_next[2] = s_data.begin_req ? '0 : win_reg[3];
        win_next[3] = s_data.sample_in;
    end

    always_comb begin
        xm1_e = ACC_W'(win_reg[0]);
        x0_e  = ACC_W'(win_reg[1]);
        x1_e  = ACC_W'(win_reg[2]);
        x2_e  = ACC_W'(win_reg[3]);
        c2_w  = x1_e - xm1_e;
        v2_w  = (x0_e - x1_e) <<< 1;
        w2_w  = c2_w + v2_w;
        a2_w  = w2_w + v2_w + (x2_e - x0_e);
        b2_w  = w2_w + a2_w;
    end

    always_comb begin
        acc_neg  = -acc_reg;
        acc_mag  = acc_reg[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_reg[MAG_W-1:0];
        rnd      = {1'b0, prod_reg} + (RND_W'(1) << (F - 1));
        q_mag    = rnd[F +: MAG_W];
        q_signed = sign_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        case (cmd.sel)
            ADD_NEG_B: addend = ACC_W'(nb2_reg);
            ADD_C:     addend = ACC_W'(c2_reg);
            ADD_X0:    addend = ACC_W'(x02_reg);
            default:   addend = '0;
        endcase
    end

    // halve with ties away from zero, then saturate
    always_comb begin
        mag_inc = {1'b0, acc_mag} + (MAG_W + 1)'(1);
        half_w  = acc_reg[ACC_W-1] ? -$signed({1'b0, mag_inc[MAG_W:1]})
                                   :  $signed({1'b0, mag_inc[MAG_W:1]});
        if (half_w > ACC_W'(32767)) begin
            sat_w = 16'sh7fff;
        end else if (half_w < -ACC_W'(32768)) begin
            sat_w = -16'sh8000;
        end else begin
            sat_w = half_w[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        step_ext = CW'(step_reg);
        if (step_ext < MIN_C) begin
            step_cl = MIN_C;
        end else if (step_ext > ONE_C) begin
            step_cl = ONE_C;
        end else begin
            step_cl = step_ext;
        end
        step_c    = step_cl[F:0];
        phase_sum = {1'b0, phase_reg} + step_c;
        made_inc  = {1'b0, made_reg} + (TOTAL_W + 1)'(1);
        done_w    = made_inc == {1'b0, total_reg};
        last_w    = phase_sum[F] || (n_reg == RUN_CNT_W'(MAX_OUTS - 1))
                    || (made_inc >= {1'b0, total_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_RESET;
            total_reg <= TOTAL_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_PHASE_STEP) begin
                step_reg <= cfg_wdata[STEP_W-1:0];
            end else if (cfg_index == REG_OUTPUT_TOTAL) begin
                total_reg <= cfg_wdata[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                win_reg[i] <= '0;
            end
            phase_reg   <= '0;
            prime_reg   <= '0;
            made_reg    <= '0;
            n_reg       <= '0;
            run_ok_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                for (int i = 0; i < 4; i++) begin
                    win_reg[i] <= win_next[i];
                end
                if (s_data.begin_req) begin
                    phase_reg <= '0;
                end
                prime_reg  <= (prime_eff == PRIME_FULL) ? prime_eff
                              : prime_eff + PRIME_W'(1);
                made_reg   <= made_eff;
                n_reg      <= '0;
                run_ok_reg <= (prime_eff == PRIME_FULL) && (made_eff < total_reg);
            end
            if (cmd.emit) begin
                phase_reg   <= phase_sum[F-1:0];
                made_reg    <= made_inc[TOTAL_W-1:0];
                n_reg       <= n_reg + RUN_CNT_W'(1);
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.coef) begin
            a2_reg  <= a2_w[19:0];
            nb2_reg <= -b2_w[20:0];
            c2_reg  <= c2_w[16:0];
            x02_reg <= x0_e[16:0] <<< 1;
        end
        if (cmd.load_a) begin
            acc_reg <= ACC_W'(a2_reg);
        end else if (cmd.add) begin
            acc_reg <= q_signed + addend;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(acc_mag) * PROD_W'(phase_reg);
            sign_reg <= acc_reg[ACC_W-1];
        end
        if (cmd.emit) begin
            out_reg.sample_out <= sat_w;
            out_reg.run_last   <= last_w;
            out_reg.total_done <= done_w;
        end
    end

    assign m_data        = out_reg;
    assign m_valid       = m_valid_reg;
    assign stat.run_ok   = run_ok_reg;
    assign stat.last     = last_w;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

// ----- rtl/core/hrs_ctrl.sv -----
// Controller: sequences load, coefficients, three multiply-add rounds and emit.
module hrs_ctrl
    import hrs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD_A,
        ST_MUL,
        ST_ADD,
        ST_FIN
    } state_t;

    state_t   state_reg, state_next;
    add_sel_t sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.coef   = 1'b1;
                state_next = stat.run_ok ? ST_LOAD_A : ST_IDLE;
            end
            ST_LOAD_A: begin
                cmd.load_a = 1'b1;
                sel_next   = ADD_NEG_B;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add = 1'b1;
                case (sel_reg)
                    ADD_NEG_B: begin
                        sel_next   = ADD_C;
                        state_next = ST_MUL;
                    end
                    ADD_C: begin
                        sel_next   = ADD_X0;
                        state_next = ST_MUL;
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.last ? ST_IDLE : ST_LOAD_A;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= ADD_NEG_B;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ----- rtl/core/hermite_resampler_top.sv -----
// Top level of the cubic Hermite audio resampler.
//
//  port group   dir  handshake           payload
//  s_*          in   s_valid / s_ready   in_beat_t  {sample_in, begin_req}
//  m_*          out  m_valid / m_ready   out_beat_t {sample_out, run_last, total_done}
//  cfg_*        in   cfg_wr_en           cfg_index, cfg_wdata (no read-back)
//
// One input beat at a time: the beat is loaded and checked, then each
// result takes an operand load, three multiply/round-add rounds on one shared
// multiplier and an emit step.
// Synchronous active-low reset; results sit in an output register, and the
// emit step waits only while that register is full and m_ready is low.
module hermite_resampler_top
    import hrs_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    hrs_datapath #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
